### src/ssdta_pkg.sv
`default_nettype none
package ssdta_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_W     = 12;
    localparam int START_W     = 12;
    localparam int PLEN_W      = 9;
    localparam int SHIFT_W     = 7;
    localparam int TLEN_W      = 13;
    localparam int CFG_W       = 13;
    localparam int OFF_W       = 8;
    localparam int POS_W       = 18;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SUM_W       = 41;
    localparam int SCORE_W     = 40;

    localparam logic [1:0] MODE_REF   = 2'd0;
    localparam logic [1:0] MODE_TRACE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] REG_PATTERN_START = 2'd0;
    localparam logic [1:0] REG_PATTERN_LEN   = 2'd1;
    localparam logic [1:0] REG_MAX_SHIFT     = 2'd2;
    localparam logic [1:0] REG_TRACE_LEN     = 2'd3;

    localparam logic KIND_ALIGN = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic                    ref_ok;
        logic                    trace_ok;
        logic                    last;
        logic                    final_mac;
        logic signed [OFF_W-1:0] off;
    } pipe_tag_t;

endpackage
`default_nettype wire

### src/ssd_trace_alignment_top.sv
`default_nettype none
// Sum-of-squared-differences trace alignment.
// Commands enter on start with mode, sample_index, sample_value and last_sample; a
// command is taken at a clock edge where start is high and busy is low.
// Mode 0 stores a reference sample into the pattern window and mode 1 stores a trace
// sample; for both busy stays low. A mode 1 beat with last_sample set
// starts the offset search. One shared subtract and square unit, fed by one read port
// of each sample memory, handles one sample pair per cycle, and the search keeps busy
// high until it ends; the result beat (result_kind 0, shift_applied, best_score) is
// on the result ports in the same cycle that busy falls.
// Mode 2 reads one aligned sample through the trace memory read port: busy is high in
// the read issue and read data states; the result beat (result_kind 1) follows them.
// Every result beat is shown for exactly one cycle on result_valid; the receiver
// cannot stall it. Configuration writes use cfg_we, cfg_index and cfg_data, take effect
// at once, and the user must make them only while idle; the block does not enforce it.
// Reset clears the registers to their defaults and the best offset to zero. The
// sample memories are not cleared and hold nothing useful until loaded.
module ssd_trace_alignment_top
    import ssdta_pkg::*;
#(
    parameter int TRACE_DEPTH   = 4096,
    parameter int PATTERN_DEPTH = 256,
    parameter int SHIFT_LIMIT   = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             mode,
    input  wire logic [INDEX_W-1:0]     sample_index,
    input  wire logic [SAMPLE_BITS-1:0] sample_value,
    input  wire logic                   last_sample,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    output logic                        result_valid,
    output logic                        result_kind,
    output logic signed [OFF_W-1:0]     shift_applied,
    output logic [SCORE_W-1:0]          best_score,
    output logic [SAMPLE_BITS-1:0]      aligned_sample
);

    localparam int PW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_SEARCH   = 2'd1;
    localparam logic [1:0] ST_RD_ISSUE = 2'd2;
    localparam logic [1:0] ST_RD_DATA  = 2'd3;

    logic [SAMPLE_BITS-1:0] ref_mem [PATTERN_DEPTH];
    logic [SAMPLE_BITS-1:0] trace_mem [TRACE_DEPTH];
    logic [SAMPLE_BITS-1:0] ref_q;
    logic [SAMPLE_BITS-1:0] trace_q;

    logic [START_W-1:0] pattern_start_reg;
    logic [PLEN_W-1:0]  pattern_len_reg;
    logic [SHIFT_W-1:0] max_shift_reg;
    logic [TLEN_W-1:0]  trace_len_reg;

    logic [1:0]              state_reg, state_next;
    logic [PLEN_W-1:0]       j_reg, j_next;
    logic signed [OFF_W-1:0] off_reg, off_next;
    logic                    issue_reg, issue_next;
    logic                    first_reg, first_next;
    logic [SUM_W-1:0]        acc_reg, acc_next;
    logic signed [OFF_W-1:0] best_offset_reg, best_offset_next;
    logic [SUM_W-1:0]        best_sum_reg, best_sum_next;
    logic [AW-1:0]           rd_addr_reg, rd_addr_next;
    logic                    rd_ok_reg, rd_ok_next;

    logic                        result_valid_reg, result_valid_next;
    logic                        result_kind_reg, result_kind_next;
    logic signed [OFF_W-1:0]     shift_applied_reg, shift_applied_next;
    logic [SCORE_W-1:0]          best_score_reg, best_score_next;
    logic [SAMPLE_BITS-1:0]      aligned_sample_reg, aligned_sample_next;

    pipe_tag_t              p1_reg, p2_reg, p3_reg, issue_tag;
    logic [SAMPLE_BITS-1:0] d_reg;
    logic [SQ_W-1:0]        sq_reg;

    logic                    accept;
    logic [TLEN_W-1:0]       tlen;
    logic [PLEN_W-1:0]       plen;
    logic [SHIFT_W-1:0]      lim;
    logic signed [OFF_W-1:0] lim_s;
    logic                    kill;
    logic [PLEN_W-1:0]       j_last;
    logic [POS_W-1:0]        rpos;
    logic signed [POS_W-1:0] tpos;
    logic signed [POS_W-1:0] rd_pos;
    logic [INDEX_W-1:0]      win_idx;
    logic                    ref_we;
    logic                    trace_we;
    logic [AW-1:0]           trace_raddr;
    logic [SAMPLE_BITS-1:0]  r_val, t_val;
    logic [SUM_W-1:0]        sum;
    logic                    win;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign tlen  = (32'(trace_len_reg) > TRACE_DEPTH) ? TLEN_W'(TRACE_DEPTH) : trace_len_reg;
    assign plen  = (32'(pattern_len_reg) > PATTERN_DEPTH) ? PLEN_W'(PATTERN_DEPTH)
                                                          : pattern_len_reg;
    assign lim   = (32'(max_shift_reg) > SHIFT_LIMIT) ? SHIFT_W'(SHIFT_LIMIT) : max_shift_reg;
    assign lim_s = $signed({1'b0, lim});
    assign kill  = (plen == '0);
    assign j_last = kill ? '0 : plen - PLEN_W'(1);

    assign rpos = POS_W'(pattern_start_reg) + POS_W'(j_reg);
    assign tpos = $signed(rpos) + POS_W'(off_reg);

    always_comb
    begin
        issue_tag           = '0;
        issue_tag.valid     = issue_reg;
        issue_tag.ref_ok    = !kill && (rpos < POS_W'(tlen));
        issue_tag.trace_ok  = !kill && !tpos[POS_W-1] && ($unsigned(tpos) < POS_W'(tlen));
        issue_tag.last      = (j_reg == j_last);
        issue_tag.final_mac = (j_reg == j_last) && (off_reg == lim_s);
        issue_tag.off       = off_reg;
    end

    assign win_idx  = sample_index - pattern_start_reg;
    assign ref_we   = accept && (mode == MODE_REF) && (sample_index >= pattern_start_reg)
                      && (32'(win_idx) < PATTERN_DEPTH);
    assign trace_we = accept && (mode == MODE_TRACE) && (32'(sample_index) < TRACE_DEPTH);
    assign trace_raddr = (state_reg == ST_SEARCH) ? AW'($unsigned(tpos)) : rd_addr_reg;

    assign rd_pos = $signed(POS_W'(sample_index)) + POS_W'(best_offset_reg);

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[PW'(win_idx)] <= sample_value;
        end
        ref_q <= ref_mem[PW'(j_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (trace_we)
        begin
            trace_mem[AW'(sample_index)] <= sample_value;
        end
        trace_q <= trace_mem[trace_raddr];
    end

    assign r_val = p1_reg.ref_ok ? ref_q : '0;
    assign t_val = p1_reg.trace_ok ? trace_q : '0;

    always_ff @(posedge clk)
    begin
        d_reg  <= (r_val > t_val) ? (r_val - t_val) : (t_val - r_val);
        sq_reg <= d_reg * d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else
        begin
            p1_reg <= (state_reg == ST_SEARCH) ? issue_tag : '0;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    assign sum = acc_reg + SUM_W'(sq_reg);
    assign win = p3_reg.valid && p3_reg.last && (first_reg || (sum < best_sum_reg));

    always_comb
    begin
        state_next          = state_reg;
        j_next              = j_reg;
        off_next            = off_reg;
        issue_next          = issue_reg;
        first_next          = first_reg;
        acc_next            = acc_reg;
        best_offset_next    = best_offset_reg;
        best_sum_next       = best_sum_reg;
        rd_addr_next        = rd_addr_reg;
        rd_ok_next          = rd_ok_reg;
        result_valid_next   = 1'b0;
        result_kind_next    = result_kind_reg;
        shift_applied_next  = shift_applied_reg;
        best_score_next     = best_score_reg;
        aligned_sample_next = aligned_sample_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_TRACE:
                        begin
                            if (last_sample)
                            begin
                                state_next = ST_SEARCH;
                                j_next     = '0;
                                off_next   = -lim_s;
                                issue_next = 1'b1;
                                first_next = 1'b1;
                                acc_next   = '0;
                            end
                        end
                        MODE_READ:
                        begin
                            state_next   = ST_RD_ISSUE;
                            rd_addr_next = AW'($unsigned(rd_pos));
                            rd_ok_next   = (TLEN_W'(sample_index) < tlen) && !rd_pos[POS_W-1]
                                           && ($unsigned(rd_pos) < POS_W'(tlen));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (issue_reg)
                begin
                    if (issue_tag.last)
                    begin
                        j_next = '0;
                        if (issue_tag.final_mac)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            off_next = off_reg + OFF_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + PLEN_W'(1);
                    end
                end
                if (p3_reg.valid)
                begin
                    if (p3_reg.last)
                    begin
                        acc_next   = '0;
                        first_next = 1'b0;
                        if (win)
                        begin
                            best_offset_next = p3_reg.off;
                            best_sum_next    = sum;
                        end
                        if (p3_reg.final_mac)
                        begin
                            state_next          = ST_IDLE;
                            result_valid_next   = 1'b1;
                            result_kind_next    = KIND_ALIGN;
                            shift_applied_next  = -best_offset_next;
                            best_score_next     = best_sum_next[SCORE_W-1:0];
                            aligned_sample_next = '0;
                        end
                    end
                    else
                    begin
                        acc_next = sum;
                    end
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                state_next          = ST_IDLE;
                result_valid_next   = 1'b1;
                result_kind_next    = KIND_READ;
                shift_applied_next  = -best_offset_reg;
                best_score_next     = '0;
                aligned_sample_next = rd_ok_reg ? trace_q : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            j_reg            <= '0;
            off_reg          <= '0;
            issue_reg        <= 1'b0;
            first_reg        <= 1'b0;
            acc_reg          <= '0;
            best_offset_reg  <= '0;
            best_sum_reg     <= '1;
            rd_ok_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            j_reg            <= j_next;
            off_reg          <= off_next;
            issue_reg        <= issue_next;
            first_reg        <= first_next;
            acc_reg          <= acc_next;
            best_offset_reg  <= best_offset_next;
            best_sum_reg     <= best_sum_next;
            rd_ok_reg        <= rd_ok_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg        <= rd_addr_next;
        result_kind_reg    <= result_kind_next;
        shift_applied_reg  <= shift_applied_next;
        best_score_reg     <= best_score_next;
        aligned_sample_reg <= aligned_sample_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_start_reg <= '0;
            pattern_len_reg   <= PLEN_W'(1);
            max_shift_reg     <= '0;
            trace_len_reg     <= TLEN_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_START: pattern_start_reg <= cfg_data[START_W-1:0];
                REG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[PLEN_W-1:0];
                REG_MAX_SHIFT:     max_shift_reg     <= cfg_data[SHIFT_W-1:0];
                REG_TRACE_LEN:     trace_len_reg     <= cfg_data[TLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign result_kind    = result_kind_reg;
    assign shift_applied  = shift_applied_reg;
    assign best_score     = best_score_reg;
    assign aligned_sample = aligned_sample_reg;

`ifndef ASSERT_OFF
    // A result beat always leaves the block idle, so two beats never touch.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beat lasted more than one cycle");

    // Each command that holds busy ends with exactly one result beat.
    a_busy_ends_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result beat");

    // The multiply-accumulate pipeline drains before the search finishes.
    a_pipe_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_reg.valid || p2_reg.valid || p3_reg.valid) |-> (state_reg == ST_SEARCH))
        else $error("accumulate pipeline active outside the search");
`endif

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

package ssdta_tb_pkg;
    import ssdta_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int TRACE_CAP  = 4096;
    localparam int WINDOW_CAP = 256;
    localparam int SHIFT_CAP  = 64;

    typedef struct {
        logic                    kind;
        logic signed [OFF_W-1:0] shift;
        logic [SCORE_W-1:0]      score;
        logic [SAMPLE_BITS-1:0]  sample;
    } align_beat_t;

    class alignment_scoreboard;
        logic [SAMPLE_BITS-1:0] window_mem [WINDOW_CAP];
        logic [SAMPLE_BITS-1:0] trace_mem [TRACE_CAP];
        logic [START_W-1:0]     reg_start;
        logic [PLEN_W-1:0]      reg_plen;
        logic [SHIFT_W-1:0]     reg_shift;
        logic [TLEN_W-1:0]      reg_tlen;
        int                     best_off;
        logic [SUM_W-1:0]       best_sum;
        align_beat_t            expected_beats [$];
        int                     errors;
        int                     n_align;
        int                     n_read;

        function new();
            foreach (window_mem[i]) window_mem[i] = '0;
            foreach (trace_mem[i]) trace_mem[i] = '0;
            reg_start = '0;
            reg_plen  = 9'd1;
            reg_shift = '0;
            reg_tlen  = 13'd4096;
            best_off  = 0;
            best_sum  = '1;
            errors    = 0;
            n_align   = 0;
            n_read    = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_PATTERN_START: reg_start = data[START_W-1:0];
                REG_PATTERN_LEN:   reg_plen  = data[PLEN_W-1:0];
                REG_MAX_SHIFT:     reg_shift = data[SHIFT_W-1:0];
                default:           reg_tlen  = data[TLEN_W-1:0];
            endcase
        endfunction

        function int trace_span();
            return (reg_tlen > TRACE_CAP) ? TRACE_CAP : int'(reg_tlen);
        endfunction

        function void add_expected(align_beat_t beat);
            expected_beats = {expected_beats, beat};
        endfunction

        function void run_alignment();
            int tl, pl, lim, off, j, rpos, pos, winner;
            longint unsigned acc, best_acc, r, t, d;
            bit found;
            tl = trace_span();
            pl = (reg_plen > WINDOW_CAP) ? WINDOW_CAP : int'(reg_plen);
            lim = (reg_shift > SHIFT_CAP) ? SHIFT_CAP : int'(reg_shift);
            found = 1'b0;
            best_acc = '1;
            winner = 0;
            for (off = -lim; off <= lim; off++)
            begin
                acc = 0;
                for (j = 0; j < pl; j++)
                begin
                    rpos = int'(reg_start) + j;
                    r = (rpos < tl) ? longint'(window_mem[j]) : 0;
                    pos = rpos + off;
                    t = (pos >= 0 && pos < tl) ? longint'(trace_mem[pos]) : 0;
                    d = (r > t) ? r - t : t - r;
                    acc += d * d;
                end
                if (!found || acc < best_acc)
                begin
                    found = 1'b1;
                    best_acc = acc;
                    winner = off;
                end
            end
            best_off = winner;
            best_sum = best_acc[SUM_W-1:0];
        endfunction

        function void note_command(logic [1:0] mode, logic [INDEX_W-1:0] index,
                                   logic [SAMPLE_BITS-1:0] value, logic last);
            align_beat_t beat;
            int w, tl, pos;
            if (mode == MODE_REF)
            begin
                w = int'(index) - int'(reg_start);
                if (w >= 0 && w < WINDOW_CAP)
                    window_mem[w] = value;
            end
            else if (mode == MODE_TRACE)
            begin
                trace_mem[index] = value;
                if (last)
                begin
                    run_alignment();
                    beat.kind   = KIND_ALIGN;
                    beat.shift  = OFF_W'(-best_off);
                    beat.score  = best_sum[SCORE_W-1:0];
                    beat.sample = '0;
                    add_expected(beat);
                end
            end
            else if (mode == MODE_READ)
            begin
                tl = trace_span();
                beat.kind   = KIND_READ;
                beat.shift  = OFF_W'(-best_off);
                beat.score  = '0;
                beat.sample = '0;
                if (int'(index) < tl)
                begin
                    pos = int'(index) + best_off;
                    if (pos >= 0 && pos < tl)
                        beat.sample = trace_mem[pos];
                end
                add_expected(beat);
            end
        endfunction

        function void check_beat(logic kind, logic signed [OFF_W-1:0] shift,
                                 logic [SCORE_W-1:0] score, logic [SAMPLE_BITS-1:0] sample);
            align_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with none expected: kind %0d", kind);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (want.kind == KIND_ALIGN)
                n_align++;
            else
                n_read++;
            if (kind !== want.kind)
            begin
                $error("result_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (shift !== want.shift)
            begin
                $error("shift_applied: expected %0d, got %0d", want.shift, shift);
                errors++;
            end
            if (score !== want.score)
            begin
                $error("best_score: expected %0d, got %0d", want.score, score);
                errors++;
            end
            if (sample !== want.sample)
            begin
                $error("aligned_sample: expected %0d, got %0d", want.sample, sample);
                errors++;
            end
        endfunction
    endclass

endpackage

module tb;
    import ssdta_pkg::*;
    import ssdta_tb_pkg::*;

    localparam int ITEMS       = 850;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 3000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             mode = MODE_REF;
    logic [INDEX_W-1:0]     sample_index = '0;
    logic [SAMPLE_BITS-1:0] sample_value = '0;
    logic                   last_sample = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = REG_PATTERN_START;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   result_valid;
    logic                   result_kind;
    logic signed [OFF_W-1:0] shift_applied;
    logic [SCORE_W-1:0]     best_score;
    logic [SAMPLE_BITS-1:0] aligned_sample;

    alignment_scoreboard sb = new();

    bit                     ref_written [WINDOW_CAP];
    bit                     trace_written [TRACE_CAP];
    logic [SAMPLE_BITS-1:0] gen_ref [WINDOW_CAP];
    int g_start;
    int g_plen;
    int g_lim;
    int g_tlen;
    int region_lo;
    int region_hi;
    int n_sent = 0;
    int n_settings = 0;
    bit idle_en = 1'b1;
    int cycle_count = 0;

    ssd_trace_alignment_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .sample_index   (sample_index),
        .sample_value   (sample_value),
        .last_sample    (last_sample),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .result_kind    (result_kind),
        .shift_applied  (shift_applied),
        .best_score     (best_score),
        .aligned_sample (aligned_sample)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_beat(result_kind, shift_applied, best_score, aligned_sample);
    end

    function automatic bit region_ready();
        int j, p;
        for (j = 0; j < g_plen; j++)
            if (g_start + j < g_tlen && !ref_written[j])
                return 1'b0;
        for (p = region_lo; p < region_hi; p++)
            if (!trace_written[p])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit read_safe(int idx);
        int pos;
        if (idx >= g_tlen)
            return 1'b1;
        pos = idx + sb.best_off;
        if (pos < 0 || pos >= g_tlen)
            return 1'b1;
        return trace_written[pos];
    endfunction

    task automatic send(input logic [1:0] m, input logic [INDEX_W-1:0] idx,
                        input logic [SAMPLE_BITS-1:0] val, input logic lst);
        int w;
        start        <= 1'b1;
        mode         <= m;
        sample_index <= idx;
        sample_value <= val;
        last_sample  <= lst;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(m, idx, val, lst);
        if (m == MODE_REF)
        begin
            w = int'(idx) - g_start;
            if (w >= 0 && w < WINDOW_CAP)
            begin
                ref_written[w] = 1'b1;
                gen_ref[w] = val;
            end
        end
        if (m == MODE_TRACE)
            trace_written[idx] = 1'b1;
        if (m != MODE_NONE)
            n_sent++;
        if (idle_en && n_sent < ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_beats.size() != 0 || busy !== 1'b0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(index, data);
    endtask

    task automatic program_regs(input int ps, input int pl, input int ms, input int tl);
        quiesce();
        write_reg(REG_PATTERN_START, CFG_W'(ps));
        write_reg(REG_PATTERN_LEN, CFG_W'(pl));
        write_reg(REG_MAX_SHIFT, CFG_W'(ms));
        write_reg(REG_TRACE_LEN, CFG_W'(tl));
        cfg_we <= 1'b0;
        g_start = ps;
        g_plen = (pl > WINDOW_CAP) ? WINDOW_CAP : pl;
        g_lim = (ms > SHIFT_CAP) ? SHIFT_CAP : ms;
        g_tlen = (tl > TRACE_CAP) ? TRACE_CAP : tl;
        region_lo = (g_start - g_lim < 0) ? 0 : g_start - g_lim;
        region_hi = g_start + g_plen + g_lim;
        if (region_hi > g_tlen)
            region_hi = g_tlen;
        if (region_hi < region_lo)
            region_hi = region_lo;
        n_settings++;
    endtask

    task automatic read_aligned(input int n);
        int k, tries, idx, top;
        bit ok;
        for (k = 0; k < n; k++)
        begin
            ok = 1'b0;
            idx = 0;
            for (tries = 0; tries < 20 && !ok; tries++)
            begin
                top = (g_tlen + 3 > TRACE_CAP - 1) ? TRACE_CAP - 1 : g_tlen + 3;
                case ($urandom_range(0, 3))
                    0: idx = $urandom_range(0, TRACE_CAP - 1);
                    1: idx = $urandom_range(0, top);
                    default:
                    begin
                        if (region_hi > region_lo)
                            idx = $urandom_range(region_lo, region_hi - 1) - sb.best_off;
                        else
                            idx = $urandom_range(0, top);
                    end
                endcase
                ok = (idx >= 0 && idx < TRACE_CAP) && read_safe(idx);
            end
            if (ok)
                send(MODE_READ, idx[INDEX_W-1:0], SAMPLE_BITS'($urandom),
                     1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send(MODE_NONE, INDEX_W'($urandom), SAMPLE_BITS'($urandom),
                    1'($urandom_range(0, 1)));
            1:
            begin
                if (g_start > 0)
                    send(MODE_REF, INDEX_W'($urandom_range(0, g_start - 1)),
                         SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
                else
                    send(MODE_REF, INDEX_W'($urandom_range(WINDOW_CAP, TRACE_CAP - 1)),
                         SAMPLE_BITS'($urandom), 1'b0);
            end
            2: read_aligned(1);
            default: send(MODE_TRACE, INDEX_W'($urandom), SAMPLE_BITS'($urandom), 1'b0);
        endcase
    endtask

    task automatic load_reference();
        int j;
        logic [SAMPLE_BITS-1:0] v;
        for (j = 0; j < g_plen; j++)
        begin
            if (g_start + j < TRACE_CAP && (g_start + j < g_tlen || $urandom_range(0, 7) == 0))
            begin
                case ($urandom_range(0, 7))
                    0: v = '0;
                    1: v = '1;
                    default: v = SAMPLE_BITS'($urandom);
                endcase
                if ($urandom_range(0, 12) == 0)
                    send_noise();
                send(MODE_REF, INDEX_W'(g_start + j), v, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic load_trace();
        int style, shift_true, p, cut, w;
        logic [SAMPLE_BITS-1:0] cval, v;
        logic lst;
        style = $urandom_range(0, 3);
        shift_true = $urandom_range(0, 2 * g_lim) - g_lim;
        cval = SAMPLE_BITS'($urandom);
        if (region_hi <= region_lo)
        begin
            send(MODE_TRACE, INDEX_W'($urandom), SAMPLE_BITS'($urandom), region_ready());
            return;
        end
        cut = region_hi - 1;
        if (region_ready() && $urandom_range(0, 4) == 0)
            cut = $urandom_range(region_lo, region_hi - 1);
        for (p = region_lo; p <= cut; p++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            w = p - shift_true - g_start;
            case (style)
                0, 1:
                begin
                    if (w >= 0 && w < g_plen && ref_written[w])
                        v = SAMPLE_BITS'(gen_ref[w] + $urandom_range(0, 2));
                    else
                        v = SAMPLE_BITS'($urandom);
                end
                2: v = SAMPLE_BITS'($urandom);
                default: v = cval;
            endcase
            lst = 1'b0;
            if (p == cut)
            begin
                trace_written[p] = 1'b1;
                lst = region_ready();
            end
            send(MODE_TRACE, p[INDEX_W-1:0], v, lst);
        end
    endtask

    task automatic run_phase(input int ps, input int pl, input int ms, input int tl);
        program_regs(ps, pl, ms, tl);
        idle_en = ($urandom_range(0, 2) != 0);
        load_reference();
        repeat ($urandom_range(1, 3))
        begin
            load_trace();
            read_aligned($urandom_range(2, 5));
        end
    endtask

    initial
    begin
        int ps, pl, ms, tl;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Trace is the reference pattern moved one sample right, so the search
        // must settle on a shift of -1 with a zero score.
        program_regs(2, 4, 2, 8);
        send(MODE_REF, 12'd2, 16'h0000, 1'b0);
        send(MODE_REF, 12'd3, 16'hFFFF, 1'b0);
        send(MODE_REF, 12'd4, 16'h1234, 1'b0);
        send(MODE_REF, 12'd5, 16'hFFFF, 1'b1);
        send(MODE_REF, 12'd1, 16'hABCD, 1'b0);
        send(MODE_REF, 12'd4095, 16'h5555, 1'b0);
        send(MODE_NONE, 12'd4095, 16'hFFFF, 1'b1);
        send(MODE_TRACE, 12'd0, 16'h0000, 1'b0);
        send(MODE_TRACE, 12'd1, 16'h0000, 1'b0);
        send(MODE_TRACE, 12'd2, 16'h0000, 1'b0);
        send(MODE_TRACE, 12'd3, 16'h0000, 1'b0);
        send(MODE_TRACE, 12'd4, 16'hFFFF, 1'b0);
        send(MODE_TRACE, 12'd5, 16'h1234, 1'b0);
        send(MODE_TRACE, 12'd6, 16'hFFFF, 1'b0);
        send(MODE_TRACE, 12'd7, 16'h8001, 1'b1);
        send(MODE_TRACE, 12'd4095, 16'hFFFF, 1'b0);
        send(MODE_READ, 12'd0, 16'hFFFF, 1'b1);
        send(MODE_READ, 12'd2, 16'h0000, 1'b0);
        send(MODE_READ, 12'd7, 16'h0000, 1'b0);
        send(MODE_READ, 12'd8, 16'h0000, 1'b0);
        send(MODE_READ, 12'd4095, 16'hFFFF, 1'b0);

        run_phase(0, 0, 5, 16);
        run_phase(4095, 511, 127, 8191);
        run_phase(0, 256, 64, 20);
        run_phase(7, 3, 64, 1);
        run_phase(3, 5, 2, 0);
        run_phase(0, 1, 0, 4096);

        while (n_sent < ITEMS)
        begin
            ps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
            pl = $urandom_range(1, 12);
            ms = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                tl = $urandom_range(1, ps + pl);
            else
                tl = ps + pl + ms + $urandom_range(0, 8);
            if (tl > TRACE_CAP)
                tl = TRACE_CAP;
            run_phase(ps, pl, ms, tl);
        end

        quiesce();
        repeat (20) @(posedge clk);
        $display("tb: %0d commands over %0d register settings, corner lengths included",
                 n_sent, n_settings);
        $display("tb: %0d alignment beats and %0d readout beats compared",
                 sb.n_align, sb.n_read);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

### ssd_trace_alignment_top.f
src/ssdta_pkg.sv
src/ssd_trace_alignment_top.sv
tb/sv/tb.sv
